>>> hdl/qvr_pkg.sv
// Package with the word types, derived widths and defaults of the quaternion vector rotator.
package qvr_pkg;

  // Width of every input and output component.
  localparam int DATA_WIDTH = 16;
  // Default fraction bits of the quaternion components.
  localparam int FRAC_BITS = 14;

  // A product of two components.
  localparam int PROD_W = 2 * DATA_WIDTH;
  // A sum of three products, which is one part of the intermediate quaternion.
  localparam int M_W = PROD_W + 2;
  // The intermediate part is split in two halves for the second multiplier stage.
  localparam int LO_W = M_W / 2;
  localparam int HI_W = M_W - LO_W;
  // Partial products: the quaternion part times the unsigned low half or the signed high half.
  localparam int LO_P_W = DATA_WIDTH + LO_W + 1;
  localparam int HI_P_W = DATA_WIDTH + HI_W;
  // A full second-stage product and the sum of two of them.
  localparam int TERM_W = DATA_WIDTH + M_W;
  localparam int PAIR_W = TERM_W + 1;

  // Input word: the vector and the quaternion.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
  } vec_word_t;

  // Output word: the rotated vector and the clipping flag.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;
    logic                         saturated;
  } rot_word_t;

  // Word after the first stage: the quaternion and the intermediate quaternion m.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [M_W-1:0]        m0;
    logic signed [M_W-1:0]        m1;
    logic signed [M_W-1:0]        m2;
    logic signed [M_W-1:0]        m3;
  } mid_word_t;

  // Word after the second stage: two partial sums for each rotated component.
  typedef struct packed {
    logic signed [PAIR_W-1:0] pa0;
    logic signed [PAIR_W-1:0] pa1;
    logic signed [PAIR_W-1:0] pa2;
    logic signed [PAIR_W-1:0] pb0;
    logic signed [PAIR_W-1:0] pb1;
    logic signed [PAIR_W-1:0] pb2;
  } outer_word_t;

endpackage

>>> hdl/qvr_mid.sv
// First half of the rotation: forms the intermediate quaternion m from the vector and q.
module qvr_mid (
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  output logic               vec_stall,
  input  qvr_pkg::vec_word_t vec_word,
  output logic               mid_valid,
  input  logic               mid_stall,
  output qvr_pkg::mid_word_t mid_word
);

  localparam int PW = qvr_pkg::PROD_W;
  localparam int DW = qvr_pkg::DATA_WIDTH;

  logic [1:0] valid;
  logic [1:0] adv;

  // Products of the first stage, one register each.
  logic signed [PW-1:0] p_xw, p_yz, p_zy;
  logic signed [PW-1:0] p_xz, p_yw, p_zx;
  logic signed [PW-1:0] p_yx, p_xy, p_zw;
  logic signed [PW-1:0] p_xx, p_yy, p_zz;
  logic signed [DW-1:0] s1_qx, s1_qy, s1_qz, s1_qw;

  qvr_pkg::mid_word_t out_reg;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[1] = !valid[1] || !mid_stall;
    adv[0] = !valid[0] || adv[1];
  end

  assign vec_stall = !adv[0];
  assign mid_valid = valid[1];
  assign mid_word  = out_reg;

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= vec_valid;
      end
      if (adv[1]) begin
        valid[1] <= valid[0];
      end
    end
  end

  // Stage one: the twelve products of vector and quaternion parts.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_xw  <= vec_word.vec_x * vec_word.quat_w;
      p_yz  <= vec_word.vec_y * vec_word.quat_z;
      p_zy  <= vec_word.vec_z * vec_word.quat_y;
      p_xz  <= vec_word.vec_x * vec_word.quat_z;
      p_yw  <= vec_word.vec_y * vec_word.quat_w;
      p_zx  <= vec_word.vec_z * vec_word.quat_x;
      p_yx  <= vec_word.vec_y * vec_word.quat_x;
      p_xy  <= vec_word.vec_x * vec_word.quat_y;
      p_zw  <= vec_word.vec_z * vec_word.quat_w;
      p_xx  <= vec_word.vec_x * vec_word.quat_x;
      p_yy  <= vec_word.vec_y * vec_word.quat_y;
      p_zz  <= vec_word.vec_z * vec_word.quat_z;
      s1_qx <= vec_word.quat_x;
      s1_qy <= vec_word.quat_y;
      s1_qz <= vec_word.quat_z;
      s1_qw <= vec_word.quat_w;
    end
  end

  // Stage two: sums of three products; the scalar part keeps a positive sign.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      out_reg.quat_x <= s1_qx;
      out_reg.quat_y <= s1_qy;
      out_reg.quat_z <= s1_qz;
      out_reg.quat_w <= s1_qw;
      out_reg.m0     <= qvr_pkg::M_W'(p_xw) - qvr_pkg::M_W'(p_yz) + qvr_pkg::M_W'(p_zy);
      out_reg.m1     <= qvr_pkg::M_W'(p_xz) + qvr_pkg::M_W'(p_yw) - qvr_pkg::M_W'(p_zx);
      out_reg.m2     <= qvr_pkg::M_W'(p_yx) - qvr_pkg::M_W'(p_xy) + qvr_pkg::M_W'(p_zw);
      out_reg.m3     <= qvr_pkg::M_W'(p_xx) + qvr_pkg::M_W'(p_yy) + qvr_pkg::M_W'(p_zz);
    end
  end

  // A stalled word at the output stays in place and keeps its value.
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (valid[1] && mid_stall) |=> (valid[1] && $stable(out_reg)))
    else $error("qvr_mid: stalled word changed");

endmodule

>>> hdl/qvr_outer.sv
// Second half of the rotation: multiplies m by q in split partial products and pairs the terms.
module qvr_outer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mid_valid,
  output logic                 mid_stall,
  input  qvr_pkg::mid_word_t   mid_word,
  output logic                 pair_valid,
  input  logic                 pair_stall,
  output qvr_pkg::outer_word_t pair_word
);

  localparam int DW     = qvr_pkg::DATA_WIDTH;
  localparam int M_W    = qvr_pkg::M_W;
  localparam int LO_W   = qvr_pkg::LO_W;
  localparam int LO_P_W = qvr_pkg::LO_P_W;
  localparam int HI_P_W = qvr_pkg::HI_P_W;
  localparam int TERM_W = qvr_pkg::TERM_W;
  localparam int NTERM  = 12;

  logic [2:0] valid;
  logic [2:0] adv;

  logic signed [DW-1:0]     q_sel [NTERM];
  logic signed [M_W-1:0]    m_sel [NTERM];
  logic signed [LO_P_W-1:0] lo_prod [NTERM];
  logic signed [HI_P_W-1:0] hi_prod [NTERM];
  logic signed [TERM_W-1:0] term [NTERM];

  qvr_pkg::outer_word_t out_reg;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[2] = !valid[2] || !pair_stall;
    adv[1] = !valid[1] || adv[2];
    adv[0] = !valid[0] || adv[1];
  end

  assign mid_stall  = !adv[0];
  assign pair_valid = valid[2];
  assign pair_word  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= mid_valid;
      end
      if (adv[1]) begin
        valid[1] <= valid[0];
      end
      if (adv[2]) begin
        valid[2] <= valid[1];
      end
    end
  end

  // Term table: which q part multiplies which m part, for x, then y, then z.
  always_comb begin
    q_sel[0]  = mid_word.quat_w;  m_sel[0]  = mid_word.m0;
    q_sel[1]  = mid_word.quat_x;  m_sel[1]  = mid_word.m3;
    q_sel[2]  = mid_word.quat_y;  m_sel[2]  = mid_word.m2;
    q_sel[3]  = mid_word.quat_z;  m_sel[3]  = mid_word.m1;
    q_sel[4]  = mid_word.quat_w;  m_sel[4]  = mid_word.m1;
    q_sel[5]  = mid_word.quat_x;  m_sel[5]  = mid_word.m2;
    q_sel[6]  = mid_word.quat_y;  m_sel[6]  = mid_word.m3;
    q_sel[7]  = mid_word.quat_z;  m_sel[7]  = mid_word.m0;
    q_sel[8]  = mid_word.quat_w;  m_sel[8]  = mid_word.m2;
    q_sel[9]  = mid_word.quat_x;  m_sel[9]  = mid_word.m1;
    q_sel[10] = mid_word.quat_y;  m_sel[10] = mid_word.m0;
    q_sel[11] = mid_word.quat_z;  m_sel[11] = mid_word.m3;
  end

  // Stage three: each product is split into low-half and high-half partial products.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < NTERM; k++) begin
        lo_prod[k] <= q_sel[k] * $signed({1'b0, m_sel[k][LO_W-1:0]});
        hi_prod[k] <= q_sel[k] * $signed(m_sel[k][M_W-1:LO_W]);
      end
    end
  end

  // Stage four: the partial products are joined into full terms.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < NTERM; k++) begin
        term[k] <= (TERM_W'(hi_prod[k]) <<< LO_W) + TERM_W'(lo_prod[k]);
      end
    end
  end

  // Stage five: terms are added in pairs with their signs.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_reg.pa0 <= qvr_pkg::PAIR_W'(term[0]) + qvr_pkg::PAIR_W'(term[1]);
      out_reg.pb0 <= qvr_pkg::PAIR_W'(term[2]) - qvr_pkg::PAIR_W'(term[3]);
      out_reg.pa1 <= qvr_pkg::PAIR_W'(term[4]) - qvr_pkg::PAIR_W'(term[5]);
      out_reg.pb1 <= qvr_pkg::PAIR_W'(term[6]) + qvr_pkg::PAIR_W'(term[7]);
      out_reg.pa2 <= qvr_pkg::PAIR_W'(term[8]) + qvr_pkg::PAIR_W'(term[9]);
      out_reg.pb2 <= qvr_pkg::PAIR_W'(term[11]) - qvr_pkg::PAIR_W'(term[10]);
    end
  end

  // An inner stage that cannot move keeps its word.
  a_outer_hold: assert property (@(posedge clk) disable iff (rst)
    (valid[1] && !adv[1]) |=> valid[1])
    else $error("qvr_outer: inner stage lost a word");

endmodule

>>> hdl/qvr_round.sv
// Final sum, rounding to nearest and saturation of the rotated components.
module qvr_round #(
  parameter int FRAC_BITS = qvr_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  qvr_pkg::outer_word_t pair_word,
  output logic                 rot_valid,
  input  logic                 rot_stall,
  output qvr_pkg::rot_word_t   rot_word
);

  localparam int DW     = qvr_pkg::DATA_WIDTH;
  localparam int PAIR_W = qvr_pkg::PAIR_W;
  localparam int SHIFT  = 2 * FRAC_BITS;
  localparam int BASE_W = (PAIR_W + 1 > SHIFT + 1) ? PAIR_W + 1 : SHIFT + 1;
  localparam int EXT_W  = BASE_W + 1;
  localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) <<< (SHIFT - 1);
  localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

  logic [1:0] valid;
  logic [1:0] adv;

  logic signed [PAIR_W-1:0] pa [3];
  logic signed [PAIR_W-1:0] pb [3];
  logic signed [EXT_W-1:0]  total [3];
  logic signed [EXT_W-1:0]  shifted [3];
  logic                     fits [3];
  logic signed [DW-1:0]     clipped [3];

  qvr_pkg::rot_word_t out_reg;

  always_comb begin
    adv[1] = !valid[1] || !rot_stall;
    adv[0] = !valid[0] || adv[1];
  end

  assign pair_stall = !adv[0];
  assign rot_valid  = valid[1];
  assign rot_word   = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= pair_valid;
      end
      if (adv[1]) begin
        valid[1] <= valid[0];
      end
    end
  end

  always_comb begin
    pa[0] = pair_word.pa0;
    pa[1] = pair_word.pa1;
    pa[2] = pair_word.pa2;
    pb[0] = pair_word.pb0;
    pb[1] = pair_word.pb1;
    pb[2] = pair_word.pb2;
  end

  // Stage six: full sum with the rounding half already added.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int c = 0; c < 3; c++) begin
        total[c] <= EXT_W'(pa[c]) + EXT_W'(pb[c]) + HALF;
      end
    end
  end

  // Drop the fraction, then clip to the output range when the upper bits disagree.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shifted[c] = total[c] >>> SHIFT;
      fits[c]    = (shifted[c][EXT_W-1:DW-1] == '0) || (shifted[c][EXT_W-1:DW-1] == '1);
      if (fits[c]) begin
        clipped[c] = shifted[c][DW-1:0];
      end else if (shifted[c][EXT_W-1]) begin
        clipped[c] = MIN_VAL;
      end else begin
        clipped[c] = MAX_VAL;
      end
    end
  end

  // Stage seven: output register.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      out_reg.rot_x     <= clipped[0];
      out_reg.rot_y     <= clipped[1];
      out_reg.rot_z     <= clipped[2];
      out_reg.saturated <= !(fits[0] && fits[1] && fits[2]);
    end
  end

  // A clipped word always carries at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (rot_valid && rot_word.saturated) |->
      (rot_word.rot_x == MAX_VAL || rot_word.rot_x == MIN_VAL ||
       rot_word.rot_y == MAX_VAL || rot_word.rot_y == MIN_VAL ||
       rot_word.rot_z == MAX_VAL || rot_word.rot_z == MIN_VAL))
    else $error("qvr_round: saturated flag without a clipped component");

endmodule

>>> hdl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotator: q * v * conj(q) in a seven-stage pipeline.
//
//   channel  direction  handshake          word
//   vec      in         vec_valid/stall    vector x, y, z and quaternion x, y, z, w
//   rot      out        rot_valid/stall    rotated x, y, z and saturated flag
//
// One word enters per clock while vec_stall is low.
// The pipeline depth is set by the two multiplier stages, the split products of the
// second multiplication and the final sum, rounding and clipping.
// Reset clears only the valid bits of the stages; data registers are not reset.
// A stall on rot holds the last stage; empty stages still fill, and vec_stall rises
// only when every stage holds a word.
module quaternion_vector_rotate #(
  parameter int FRAC_BITS = qvr_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  output logic               vec_stall,
  input  qvr_pkg::vec_word_t vec_word,
  output logic               rot_valid,
  input  logic               rot_stall,
  output qvr_pkg::rot_word_t rot_word
);

  logic                 mid_valid;
  logic                 mid_stall;
  qvr_pkg::mid_word_t   mid_word;
  logic                 pair_valid;
  logic                 pair_stall;
  qvr_pkg::outer_word_t pair_word;

  // Intermediate quaternion m.
  qvr_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec_word  (vec_word),
    .mid_valid (mid_valid),
    .mid_stall (mid_stall),
    .mid_word  (mid_word)
  );

  // Second multiplication and paired sums.
  qvr_outer u_outer (
    .clk        (clk),
    .rst        (rst),
    .mid_valid  (mid_valid),
    .mid_stall  (mid_stall),
    .mid_word   (mid_word),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair_word  (pair_word)
  );

  // Final sum, rounding and clipping.
  qvr_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair_word  (pair_word),
    .rot_valid  (rot_valid),
    .rot_stall  (rot_stall),
    .rot_word   (rot_word)
  );

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rot_valid)
    else $error("quaternion_vector_rotate: output valid after reset");

  // The input is held back only while a finished word waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> (rot_valid && rot_stall))
    else $error("quaternion_vector_rotate: input stalled with output free");

endmodule

>>> sim/tb_quaternion_vector_rotate.sv
// Rotator testbench: directed and random words, checked against a predictor or a typed-in answer.
module tb_quaternion_vector_rotate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = qvr_pkg::DATA_WIDTH;
  localparam int FRAC = qvr_pkg::FRAC_BITS;
  localparam longint WORD_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint WORD_MIN = -(longint'(1) <<< (DW - 1));
  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    qvr_pkg::vec_word_t word;
    bit                 known;
    qvr_pkg::rot_word_t answer;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               vec_valid = 1'b0;
  logic               vec_stall;
  qvr_pkg::vec_word_t vec_word = '0;
  logic               rot_valid;
  logic               rot_stall = 1'b0;
  qvr_pkg::rot_word_t rot_word;

  // Side band that travels with the word on the input: a typed-in answer, if any.
  logic               row_known = 1'b0;
  qvr_pkg::rot_word_t row_answer = '0;

  stim_row_t stim_rows[$];
  qvr_pkg::rot_word_t rotated_due[$];
  qvr_pkg::rot_word_t due_word;

  int cycles = 0;
  int words_in = 0;
  int results_seen = 0;
  int clipped_seen = 0;
  int input_stalls = 0;
  int fail_count = 0;
  int hold_left = 0;
  int stall_left = 0;
  int next_hold_at = 400;

  quaternion_vector_rotate dut (
    .clk       (clk),
    .rst       (rst),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec_word  (vec_word),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot_word  (rot_word)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Round the exact Q(2*FRAC) value to nearest, ties upward, then clip.
  // The top bit of the result is the clip flag.
  function automatic logic [DW:0] round_to_word(input longint acc);
    longint v;
    v = (acc + (longint'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
    if (v > WORD_MAX) return {1'b1, DW'(WORD_MAX)};
    if (v < WORD_MIN) return {1'b1, DW'(WORD_MIN)};
    return {1'b0, DW'(v)};
  endfunction

  // Expected rotation q * v * conj(q), exact up to the final rounding.
  function automatic qvr_pkg::rot_word_t rotate_vector(input qvr_pkg::vec_word_t w);
    longint x, y, z, qx, qy, qz, qw, m0, m1, m2, m3;
    logic [DW:0] rv;
    qvr_pkg::rot_word_t res;
    x = $signed(w.vec_x);
    y = $signed(w.vec_y);
    z = $signed(w.vec_z);
    qx = $signed(w.quat_x);
    qy = $signed(w.quat_y);
    qz = $signed(w.quat_z);
    qw = $signed(w.quat_w);
    m0 = x * qw - y * qz + z * qy;
    m1 = x * qz + y * qw - z * qx;
    m2 = y * qx - x * qy + z * qw;
    m3 = x * qx + y * qy + z * qz;
    res.saturated = 1'b0;
    rv = round_to_word(qw * m0 + qx * m3 + qy * m2 - qz * m1);
    res.rot_x = rv[DW-1:0];
    res.saturated |= rv[DW];
    rv = round_to_word(qw * m1 - qx * m2 + qy * m3 + qz * m0);
    res.rot_y = rv[DW-1:0];
    res.saturated |= rv[DW];
    rv = round_to_word(qw * m2 + qx * m1 - qy * m0 + qz * m3);
    res.rot_z = rv[DW-1:0];
    res.saturated |= rv[DW];
    return res;
  endfunction

  function automatic void add_row(input int vx, input int vy, input int vz, input int qx,
                                  input int qy, input int qz, input int qw, input bit known,
                                  input int ax, input int ay, input int az, input bit asat);
    stim_row_t r;
    r.word.vec_x = DW'(vx);
    r.word.vec_y = DW'(vy);
    r.word.vec_z = DW'(vz);
    r.word.quat_x = DW'(qx);
    r.word.quat_y = DW'(qy);
    r.word.quat_z = DW'(qz);
    r.word.quat_w = DW'(qw);
    r.known = known;
    r.answer.rot_x = DW'(ax);
    r.answer.rot_y = DW'(ay);
    r.answer.rot_z = DW'(az);
    r.answer.saturated = asat;
    stim_rows.push_back(r);
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Replace most fields with a boundary, unit or one-half value; the rest keep their raw bits.
  function automatic logic [DW-1:0] corner_value(input logic [DW-1:0] raw);
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DW - 1){1'b0}}};
      1: return {1'b0, {(DW - 1){1'b1}}};
      2: return '0;
      3: return DW'(1);
      4: return '1;
      5: return DW'(1 << FRAC);
      6: return DW'(-(1 << FRAC));
      7: return DW'(1 << (FRAC - 1));
      default: return raw;
    endcase
  endfunction

  // Offer one word after an optional gap and hold it until it is taken.
  task automatic offer_vector(input qvr_pkg::vec_word_t w, input bit known,
                              input qvr_pkg::rot_word_t answer, input int gap);
    if (gap > 0) begin
      vec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec_word <= w;
    row_known <= known;
    row_answer <= answer;
    do @(posedge clk); while (vec_stall);
  endtask

  // Receiver: random stalls, calm stretches, and long hold-offs to fill the pipeline.
  always @(posedge clk) begin
    if (rst) begin
      rot_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && words_in >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at = next_hold_at + 700;
      end
      if (hold_left == 0 && stall_left == 0) stall_left = pick_gap(((cycles / 300) % 3) == 1);
      if (hold_left > 0) begin
        rot_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
        rot_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        rot_stall <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest pending answer, then record new words.
  always @(posedge clk) begin
    if (!rst) begin
      if (rot_valid && !rot_stall) begin
        if (rotated_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: x=%0d y=%0d z=%0d sat=%0b",
                     rot_word.rot_x, rot_word.rot_y, rot_word.rot_z, rot_word.saturated);
        end else begin
          due_word = rotated_due.pop_front();
          if (rot_word.rot_x !== due_word.rot_x || rot_word.rot_y !== due_word.rot_y ||
              rot_word.rot_z !== due_word.rot_z ||
              rot_word.saturated !== due_word.saturated) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch %0d: exp x=%0d y=%0d z=%0d s=%0b, got x=%0d y=%0d z=%0d s=%0b",
                       results_seen, due_word.rot_x, due_word.rot_y, due_word.rot_z,
                       due_word.saturated, rot_word.rot_x, rot_word.rot_y, rot_word.rot_z,
                       rot_word.saturated);
          end
          results_seen++;
          if (due_word.saturated) clipped_seen++;
        end
      end
      if (vec_valid && !vec_stall) begin
        rotated_due.push_back(row_known ? row_answer : rotate_vector(vec_word));
        words_in++;
      end
      if (vec_valid && vec_stall) input_stalls++;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: directed rows first, then random words, then drain and report.
  initial begin
    qvr_pkg::vec_word_t w;
    int pick;
    int k;

    // Zero and identity rotations pass the vector through unchanged.
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(100, -200, 300, 0, 0, 0, 16384, 1, 100, -200, 300, 0);
    add_row(32767, -32768, 0, 0, 0, 0, 16384, 1, 32767, -32768, 0, 0);
    add_row(-32768, -32768, -32768, 0, 0, 0, 16384, 1, -32768, -32768, -32768, 0);
    // Scale by about four: clipped high and low.
    add_row(32767, 32767, 32767, 0, 0, 0, 32767, 1, 32767, 32767, 32767, 1);
    add_row(-32768, -32768, -32768, 0, 0, 0, -32768, 1, -32768, -32768, -32768, 1);
    // Scale by about two clips only x.
    add_row(32767, 0, 0, 0, 0, 0, 23170, 1, 32767, 0, 0, 1);
    // Scale by one half: ties round toward plus infinity.
    add_row(1, 0, 0, 8192, 0, 0, 8192, 1, 1, 0, 0, 0);
    add_row(-1, 0, 0, 8192, 0, 0, 8192, 1, 0, 0, 0, 0);
    add_row(3, 0, 0, 8192, 0, 0, 8192, 1, 2, 0, 0, 0);
    add_row(-3, 0, 0, 8192, 0, 0, 8192, 1, -1, 0, 0, 0);
    // Half turn about x negates y and z.
    add_row(10, 20, 30, 16384, 0, 0, 0, 1, 10, -20, -30, 0);
    // Quarter turn about z, non-unit and extreme quaternions.
    add_row(1000, 0, 0, 0, 0, 11585, 11585, 0, 0, 0, 0, 0);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0);
    add_row(12345, -6789, -32768, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0);
    add_row(32767, 0, -1, -32768, 32767, 0, 1, 0, 0, 0, 0, 0);
    add_row(32767, -32768, 32767, 1, 1, 1, 1, 0, 0, 0, 0, 0);
    add_row(-32768, 32767, 2, 0, 0, 0, 11585, 0, 0, 0, 0, 0);
    add_row(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0);
    add_row(777, -4321, 9000, 5000, -7000, 3000, 13000, 0, 0, 0, 0, 0);

    while (rst) @(posedge clk);

    for (k = 0; k < stim_rows.size(); k++)
      offer_vector(stim_rows[k].word, stim_rows[k].known, stim_rows[k].answer, pick_gap(1'b0));

    for (k = 0; k < RANDOM_WORDS; k++) begin
      w.vec_x = DW'($urandom());
      w.vec_y = DW'($urandom());
      w.vec_z = DW'($urandom());
      w.quat_x = DW'($urandom());
      w.quat_y = DW'($urandom());
      w.quat_z = DW'($urandom());
      w.quat_w = DW'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Raw bits everywhere: mostly clipped results.
      end else if (pick < 70) begin
        // Quaternion with squared norm up to about two: mostly in range.
        w.quat_x = DW'(int'($urandom_range(0, 23170)) - 11585);
        w.quat_y = DW'(int'($urandom_range(0, 23170)) - 11585);
        w.quat_z = DW'(int'($urandom_range(0, 23170)) - 11585);
        w.quat_w = DW'(int'($urandom_range(0, 23170)) - 11585);
      end else if (pick < 85) begin
        // Short vectors exercise rounding near zero.
        w.vec_x = DW'(int'($urandom_range(0, 512)) - 256);
        w.vec_y = DW'(int'($urandom_range(0, 512)) - 256);
        w.vec_z = DW'(int'($urandom_range(0, 512)) - 256);
      end else begin
        w.vec_x = corner_value(w.vec_x);
        w.vec_y = corner_value(w.vec_y);
        w.vec_z = corner_value(w.vec_z);
        w.quat_x = corner_value(w.quat_x);
        w.quat_y = corner_value(w.quat_y);
        w.quat_z = corner_value(w.quat_z);
        w.quat_w = corner_value(w.quat_w);
      end
      offer_vector(w, 1'b0, '0, pick_gap(((k / 150) % 3) == 1));
    end
    vec_valid <= 1'b0;
    row_known <= 1'b0;

    while (rotated_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words rotated (%0d directed, %0d random), %0d of them clipped",
             results_seen, stim_rows.size(), RANDOM_WORDS, clipped_seen);
    $display("input held off on %0d cycles, %0d failures", input_stalls, fail_count);
    if (fail_count == 0 && rotated_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/qvr_pkg.sv
hdl/qvr_mid.sv
hdl/qvr_outer.sv
hdl/qvr_round.sv
hdl/quaternion_vector_rotate.sv
sim/tb_quaternion_vector_rotate.sv
